// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked check, also active during reset.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// File: design/kde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kde_pkg;

    localparam int NUM_KEYS  = 4;
    localparam int KEY_W     = 2;
    localparam int TICK_W    = 16;
    localparam int RAM_AW    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 16;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    localparam logic              RST_PRESS_LEVEL    = 1'b0;
    localparam logic [TICK_W-1:0] RST_DEBOUNCE_TICKS = 16'd2;
    localparam logic [TICK_W-1:0] RST_LONG_TICKS     = 16'd50;
    localparam logic [TICK_W-1:0] RST_REPEAT_TICKS   = 16'd20;

    typedef enum logic [4:0] {
        PH_IDLE        = 5'b00001,
        PH_DEB_PRESS   = 5'b00010,
        PH_PRESSED     = 5'b00100,
        PH_LONG        = 5'b01000,
        PH_DEB_RELEASE = 5'b10000
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_SHORT   = 3'd1,
        EV_LONG    = 3'd2,
        EV_REPEAT  = 3'd3,
        EV_RELEASE = 3'd4
    } t_event;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESS_LEVEL    = 2'd0,
        REG_DEBOUNCE_TICKS = 2'd1,
        REG_LONG_TICKS     = 2'd2,
        REG_REPEAT_TICKS   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        t_phase              phase;
        logic [TICK_W-1:0]   tick_count;
        logic [TICK_W-1:0]   repeat_count;
        logic                long_mark;
    } t_key_state;

    typedef struct packed {
        logic                press_level;
        logic [TICK_W-1:0]   debounce_ticks;
        logic [TICK_W-1:0]   long_ticks;
        logic [TICK_W-1:0]   repeat_ticks;
    } t_cfg;

    localparam int KEY_STATE_W = $bits(t_key_state);

    localparam t_key_state KEY_STATE_RST = '{
        phase:        PH_IDLE,
        tick_count:   '0,
        repeat_count: '0,
        long_mark:    1'b0
    };

endpackage

`default_nettype wire

// File: design/kde_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module kde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/kde_update.sv
`timescale 1ns / 1ps
`default_nettype none

module kde_update (
    input  wire kde_pkg::t_key_state i_state,
    input  wire logic                i_pin_level,
    input  wire kde_pkg::t_cfg       i_cfg,
    output kde_pkg::t_key_state      o_state,
    output kde_pkg::t_event          o_event
);

    logic                          act;
    logic [kde_pkg::TICK_W-1:0]    tick_inc;
    logic [kde_pkg::TICK_W-1:0]    rep_inc;

    assign act      = (i_pin_level == i_cfg.press_level);
    assign tick_inc = (i_state.tick_count == kde_pkg::TICK_MAX) ?
                      i_state.tick_count : i_state.tick_count + 1'b1;
    assign rep_inc  = (i_state.repeat_count == kde_pkg::TICK_MAX) ?
                      i_state.repeat_count : i_state.repeat_count + 1'b1;

    always_comb begin
        o_state = i_state;
        o_event = kde_pkg::EV_NONE;
        case (i_state.phase)
            kde_pkg::PH_IDLE: begin
                if (act) begin
                    o_state.phase      = kde_pkg::PH_DEB_PRESS;
                    o_state.tick_count = '0;
                end
            end
            kde_pkg::PH_DEB_PRESS: begin
                o_state.tick_count = tick_inc;
                if (tick_inc >= i_cfg.debounce_ticks) begin
                    o_state.tick_count = '0;
                    if (act) begin
                        o_state.phase     = kde_pkg::PH_PRESSED;
                        o_state.long_mark = 1'b0;
                        o_event           = kde_pkg::EV_SHORT;
                    end else begin
                        o_state.phase = kde_pkg::PH_IDLE;
                    end
                end
            end
            kde_pkg::PH_PRESSED: begin
                o_state.tick_count = tick_inc;
                if (tick_inc >= i_cfg.long_ticks) begin
                    o_state.phase        = kde_pkg::PH_LONG;
                    o_state.tick_count   = '0;
                    o_state.repeat_count = '0;
                    o_state.long_mark    = 1'b1;
                    o_event              = kde_pkg::EV_LONG;
                end else if (!act) begin
                    o_state.phase      = kde_pkg::PH_DEB_RELEASE;
                    o_state.tick_count = '0;
                end
            end
            kde_pkg::PH_LONG: begin
                if (act) begin
                    o_state.repeat_count = rep_inc;
                    if (i_cfg.repeat_ticks != '0 && rep_inc >= i_cfg.repeat_ticks) begin
                        o_state.repeat_count = '0;
                        o_event              = kde_pkg::EV_REPEAT;
                    end
                end else begin
                    o_state.phase      = kde_pkg::PH_DEB_RELEASE;
                    o_state.tick_count = '0;
                end
            end
            kde_pkg::PH_DEB_RELEASE: begin
                o_state.tick_count = tick_inc;
                if (tick_inc >= i_cfg.debounce_ticks) begin
                    o_state.tick_count = '0;
                    if (!act) begin
                        o_state.phase = kde_pkg::PH_IDLE;
                        o_event       = kde_pkg::EV_RELEASE;
                    end else begin
                        o_state.phase = i_state.long_mark ? kde_pkg::PH_LONG
                                                          : kde_pkg::PH_PRESSED;
                    end
                end
            end
            default: begin
                o_state.phase = kde_pkg::PH_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/key_debounce_event_fsm.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Per-key debounce and press event engine.
// Input stream: one scan-tick sample per transfer, key number and raw pin level.
// Output stream: one transfer per sample, key number and event code
// (none, short, long, repeat, release).
// Configuration channel: write active level, debounce, long and repeat tick counts
// by register index; always ready, write only while the stream is idle.
// Pipeline: the sample is registered in the lookup stage, then its result in the output register.
// Throughput: one sample per cycle while the output is not stalled; the per-key state
// RAM is read at input transfer and written as the sample leaves the lookup stage, a
// forwarding register covers back to back samples of the same key.
// Reset: all keys idle with cleared counters through per-key valid bits, no
// clearing pass; registers return to their defaults.
// Receiver stall: the output register holds, one more sample is taken into the
// lookup stage, then s_axis_tready drops until the output is taken.
module key_debounce_event_fsm (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [1:0] key_index, [2] pin_level, [7:3] zero
    input  wire logic [kde_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [1:0] key_number, [4:2] event_code, [7:5] zero
    output logic      [kde_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [kde_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [kde_pkg::CFG_DW-1:0]        i_cfg_data
);

    kde_pkg::t_cfg                     r_cfg;

    logic                              r_s1_vld;
    logic [kde_pkg::KEY_W-1:0]         r_s1_key;
    logic                              r_s1_pin;

    logic                              r_out_vld;
    logic [kde_pkg::KEY_W-1:0]         r_out_key;
    kde_pkg::t_event                   r_out_evt;

    logic                              r_fwd_vld;
    logic [kde_pkg::KEY_W-1:0]         r_fwd_key;
    kde_pkg::t_key_state               r_fwd_state;

    logic [kde_pkg::NUM_KEYS-1:0]      r_valid;

    logic                              s_accept;
    logic                              out_free;
    logic                              s1_adv;
    logic                              s1_in_range;
    logic                              wr_en;
    logic [kde_pkg::RAM_AW-1:0]        rd_addr;
    logic [kde_pkg::RAM_AW-1:0]        wr_addr;
    logic [kde_pkg::KEY_STATE_W-1:0]   ram_rd_data;
    kde_pkg::t_key_state               s1_state;
    kde_pkg::t_key_state               upd_state;
    kde_pkg::t_event                   upd_evt;
    kde_pkg::t_event                   n_out_evt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_level    <= kde_pkg::RST_PRESS_LEVEL;
            r_cfg.debounce_ticks <= kde_pkg::RST_DEBOUNCE_TICKS;
            r_cfg.long_ticks     <= kde_pkg::RST_LONG_TICKS;
            r_cfg.repeat_ticks   <= kde_pkg::RST_REPEAT_TICKS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (kde_pkg::t_cfg_reg'(i_cfg_index))
                kde_pkg::REG_PRESS_LEVEL:    r_cfg.press_level    <= i_cfg_data[0];
                kde_pkg::REG_DEBOUNCE_TICKS: r_cfg.debounce_ticks <= i_cfg_data;
                kde_pkg::REG_LONG_TICKS:     r_cfg.long_ticks     <= i_cfg_data;
                kde_pkg::REG_REPEAT_TICKS:   r_cfg.repeat_ticks   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign out_free      = !r_out_vld || m_axis_tready;
    assign s1_adv        = r_s1_vld && out_free;
    assign s_axis_tready = !r_s1_vld || out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign rd_addr     = kde_pkg::RAM_AW'(s_axis_tdata[kde_pkg::KEY_W-1:0]);
    assign wr_addr     = kde_pkg::RAM_AW'(r_s1_key);
    assign s1_in_range = int'(r_s1_key) < kde_pkg::NUM_KEYS;
    assign wr_en       = s1_adv && s1_in_range;

    kde_ram #(
        .WIDTH (kde_pkg::KEY_STATE_W),
        .DEPTH (kde_pkg::NUM_KEYS)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (upd_state),
        .i_rd_en   (s_accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        if (r_fwd_vld && r_fwd_key == r_s1_key) begin
            s1_state = r_fwd_state;
        end else if (r_valid[wr_addr]) begin
            s1_state = kde_pkg::t_key_state'(ram_rd_data);
        end else begin
            s1_state = kde_pkg::KEY_STATE_RST;
        end
    end

    kde_update u_update (
        .i_state     (s1_state),
        .i_pin_level (r_s1_pin),
        .i_cfg       (r_cfg),
        .o_state     (upd_state),
        .o_event     (upd_evt)
    );

    assign n_out_evt = s1_in_range ? upd_evt : kde_pkg::EV_NONE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_valid   <= '0;
        end else begin
            if (s_accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (wr_en) begin
                r_fwd_vld        <= 1'b1;
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_key <= s_axis_tdata[kde_pkg::KEY_W-1:0];
            r_s1_pin <= s_axis_tdata[kde_pkg::KEY_W];
        end
        if (s1_adv) begin
            r_out_key <= r_s1_key;
            r_out_evt <= n_out_evt;
        end
        if (wr_en) begin
            r_fwd_key   <= r_s1_key;
            r_fwd_state <= upd_state;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {(kde_pkg::M_TDATA_W - kde_pkg::KEY_W - 3)'(0),
                            r_out_evt, r_out_key};

    `ASSERT_ALWAYS(a_stall_cause, !s_axis_tready |-> (r_s1_vld && r_out_vld),
                   "input stalled without a full pipeline")
    `ASSERT_CLK(a_short_source,
                (s1_adv && upd_evt == kde_pkg::EV_SHORT) |->
                    (s1_state.phase == kde_pkg::PH_DEB_PRESS),
                "short event outside press debounce")
    `ASSERT_CLK(a_write_marks_valid,
                wr_en |=> (r_valid[$past(wr_addr)] && r_fwd_vld),
                "state write not marked valid")

endmodule

`default_nettype wire
